// ===== rtl/bprf_pkg.sv =====
// Package: shared types and codes for the byte pipe ring FIFO.
`timescale 1ns / 1ps
package bprf_pkg;

  localparam logic [2:0] REQ_WRITE    = 3'd0;
  localparam logic [2:0] REQ_READ     = 3'd1;
  localparam logic [2:0] REQ_CLOSE_WR = 3'd2;
  localparam logic [2:0] REQ_CLOSE_RD = 3'd3;
  localparam logic [2:0] REQ_REOPEN   = 3'd4;

  localparam logic [1:0] STAT_OK          = 2'd0;
  localparam logic [1:0] STAT_WOULD_BLOCK = 2'd1;
  localparam logic [1:0] STAT_END_STREAM  = 2'd2;
  localparam logic [1:0] STAT_CLOSED      = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FINISH,
    S_RESP
  } state_t;

  typedef struct packed {
    logic       load;
    logic       do_write;
    logic       do_read;
    logic       clr_writer;
    logic       clr_reader;
    logic       reopen;
    logic       set_status;
    logic [1:0] status;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       full;
    logic       empty;
    logic       reader_open;
    logic       writer_open;
  } stat_t;

endpackage

// ===== rtl/byte_pipe_ring_fifo.sv =====
// Top level: byte pipe ring FIFO, controller plus datapath.
//
// Usage: one request channel (in_valid/in_ready, req_type, wr_byte) and one
// result channel (out_valid/out_ready, rd_byte, status, fill_level). Each
// request gives exactly one result. Requests: write a byte, read a byte,
// close the writer, close the reader, reopen the pipe. A request that can't
// proceed never stalls; it returns would_block, end_of_stream or
// closed_error in status. The pipe holds up to DEPTH-1 bytes.
// The block handles one request at a time: load, decide and update,
// byte store read, result. The registered read of the byte store sets
// the extra step.
// Reset: both positions cleared, both ends open, in_ready high; stored
// bytes are not cleared and are never read before being written.
// Receiver stall: the result holds steady in the output registers with
// out_valid high, and no new request is accepted until it is taken.
`timescale 1ns / 1ps
module byte_pipe_ring_fifo
  import bprf_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] req_type,
  input  logic [7:0] wr_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] rd_byte,
  output logic [1:0] status,
  output logic [7:0] fill_level
);

  cmd_t  cmd;
  stat_t stat;

  bprf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bprf_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_type  (req_type),
    .wr_byte   (wr_byte),
    .cmd       (cmd),
    .stat      (stat),
    .rd_byte   (rd_byte),
    .status    (status),
    .fill_level(fill_level)
  );

endmodule

// ===== rtl/bprf_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module bprf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/bprf_ctrl.sv =====
// Controller: request sequencing and per-request decision.
`timescale 1ns / 1ps
module bprf_ctrl
  import bprf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_EXEC;
      S_EXEC:   state_next = S_FINISH;
      S_FINISH: state_next = S_RESP;
      S_RESP:   if (out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EXEC: begin
        cmd.set_status = 1'b1;
        cmd.status     = STAT_OK;
        case (stat.req_type)
          REQ_WRITE: begin
            if (!stat.reader_open || !stat.writer_open) begin
              cmd.status = STAT_CLOSED;
            end else if (stat.full) begin
              cmd.status = STAT_WOULD_BLOCK;
            end else begin
              cmd.do_write = 1'b1;
            end
          end
          REQ_READ: begin
            if (!stat.reader_open) begin
              cmd.status = STAT_CLOSED;
            end else if (stat.empty) begin
              cmd.status = stat.writer_open ? STAT_WOULD_BLOCK : STAT_END_STREAM;
            end else begin
              cmd.do_read = 1'b1;
            end
          end
          REQ_CLOSE_WR: begin
            if (!stat.writer_open) begin
              cmd.status = STAT_CLOSED;
            end else begin
              cmd.clr_writer = 1'b1;
            end
          end
          REQ_CLOSE_RD: begin
            if (!stat.reader_open) begin
              cmd.status = STAT_CLOSED;
            end else begin
              cmd.clr_reader = 1'b1;
            end
          end
          REQ_REOPEN: begin
            cmd.reopen = 1'b1;
          end
          default: begin
            cmd.status = STAT_CLOSED;
          end
        endcase
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
      end
      S_RESP: begin
        out_valid = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/bprf_dp.sv =====
// Datapath: positions, end flags, byte store and result registers.
`timescale 1ns / 1ps
module bprf_dp
  import bprf_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [2:0] req_type,
  input  logic [7:0] wr_byte,
  input  cmd_t       cmd,
  output stat_t      stat,
  output logic [7:0] rd_byte,
  output logic [1:0] status,
  output logic [7:0] fill_level
);

  localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);

  logic [2:0]    req_q;
  logic [7:0]    wr_byte_q;
  logic [AW-1:0] read_pos;
  logic [AW-1:0] write_pos;
  logic          reader_open;
  logic          writer_open;
  logic          rd_ok;
  logic [AW-1:0] rp_inc;
  logic [AW-1:0] wp_inc;
  logic [AW:0]   diff_wrap;
  logic [AW-1:0] count;
  logic [AW+7:0] count_ext;
  logic [7:0]    ram_rdata;

  assign rp_inc = (read_pos == LAST) ? '0 : read_pos + AW'(1);
  assign wp_inc = (write_pos == LAST) ? '0 : write_pos + AW'(1);

  assign diff_wrap = {1'b0, write_pos} + DEPTH_W - {1'b0, read_pos};
  assign count     = (write_pos >= read_pos) ? (write_pos - read_pos) : diff_wrap[AW-1:0];
  assign count_ext = {8'b0, count};

  assign stat.req_type    = req_q;
  assign stat.full        = (wp_inc == read_pos);
  assign stat.empty       = (read_pos == write_pos);
  assign stat.reader_open = reader_open;
  assign stat.writer_open = writer_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      read_pos    <= '0;
      write_pos   <= '0;
      reader_open <= 1'b1;
      writer_open <= 1'b1;
    end else begin
      if (cmd.reopen) begin
        read_pos    <= '0;
        write_pos   <= '0;
        reader_open <= 1'b1;
        writer_open <= 1'b1;
      end
      if (cmd.do_write) begin
        write_pos <= wp_inc;
      end
      if (cmd.do_read) begin
        read_pos <= rp_inc;
      end
      if (cmd.clr_writer) begin
        writer_open <= 1'b0;
      end
      if (cmd.clr_reader) begin
        reader_open <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q     <= req_type;
      wr_byte_q <= wr_byte;
    end
    if (cmd.set_status) begin
      status <= cmd.status;
      rd_ok  <= cmd.do_read;
    end
    if (cmd.finish) begin
      rd_byte    <= rd_ok ? ram_rdata : 8'd0;
      fill_level <= count_ext[7:0];
    end
  end

  bprf_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (cmd.do_write),
    .waddr(write_pos),
    .wdata(wr_byte_q),
    .re   (cmd.do_read),
    .raddr(read_pos),
    .rdata(ram_rdata)
  );

endmodule
